// ===== design/btffa_pkg.sv =====
package btffa_pkg;

	localparam int ARENA_WORDS = 1024;
	localparam int MAX_HANDLES = 64;
	localparam int AW = $clog2(ARENA_WORDS);
	localparam int HW = $clog2(MAX_HANDLES);
	// tag word: size in words shifted left by one, allocated flag in bit 0
	localparam int SW = AW + 1;
	localparam int TW = SW + 1;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ALLOC   = 2'd0;
	localparam cmd_t CMD_FREE    = 2'd1;
	localparam cmd_t CMD_RESOLVE = 2'd2;
	localparam cmd_t CMD_UNUSED  = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_ZERO     = 3'd1;
	localparam status_t ST_NOMEM    = 3'd2;
	localparam status_t ST_BADH     = 3'd3;
	localparam status_t ST_HFULL    = 3'd4;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,      // latch request, set scan pointer 0 (allocate) or handle start
		OP_RD_PTR,    // latch size of tag at scan pointer
		OP_STEP,      // advance scan pointer by block size
		OP_HSCAN,     // advance handle search
		OP_WR_A,      // write header of allocated block
		OP_WR_B,      // write footer of allocated block
		OP_WR_C,      // write header of remainder
		OP_WR_D,      // write footer of remainder
		OP_BIND,      // bind handle
		OP_F_RDS,     // read header of freed block
		OP_F_RDN,     // read next neighbour header
		OP_F_RDP,     // read previous neighbour footer
		OP_F_WRH,     // write merged header
		OP_F_WRF,     // write merged footer and unbind
		OP_CLR        // clear-pass write
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		logic clr_done;
		logic size_zero;
		logic scan_end;      // no fit possible
		logic fit;           // current tag is a fitting free block
		logic h_found;
		logic h_end;
		logic hok;
		logic split;
		logic nx_merge;
		logic pv_merge;
	} sts_t;

endpackage

// ===== design/btffa_datapath.sv =====
module btffa_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  btffa_pkg::ctl_t               ctl,
	output btffa_pkg::sts_t               sts,
	input  logic [1:0]                    cmd,
	input  logic [13:0]                   size_bytes,
	input  logic [5:0]                    handle_in,
	output logic [btffa_pkg::HW-1:0]      hsel,
	output logic [btffa_pkg::AW-1:0]      base
);

	localparam int AW = btffa_pkg::AW;
	localparam int SW = btffa_pkg::SW;
	localparam int TW = btffa_pkg::TW;
	localparam int HW = btffa_pkg::HW;
	localparam int MAX_H = btffa_pkg::MAX_HANDLES;

	// tag memory, one write and one registered read a cycle
	logic [TW-1:0] mem [btffa_pkg::ARENA_WORDS];
	logic [TW-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [TW-1:0] wdata;
	logic          we;

	// handle table: valid bits in flops, block start per handle
	logic [MAX_H-1:0] hvalid_q;
	logic [AW-1:0] hstart_q [MAX_H];

	logic [SW-1:0] need_q, p_q, sz_q, s_q;
	logic [AW:0]   clr_q;
	logic [HW-1:0] h_q;
	logic [5:0]    hin_q;
	logic          hok_q;

	logic [SW-1:0] rsz;
	logic          ralloc;
	logic [SW:0]   pend;
	logic [11:0]   nwords;

	assign rsz    = rdata_q[TW-1:1];
	assign ralloc = rdata_q[0];
	assign pend   = {1'b0, p_q} + {1'b0, rsz};
	assign nwords = 12'((15'(size_bytes) + 15'd7) >> 3);

	// read address and write port selection
	always_comb begin
		raddr = p_q[AW-1:0];
		we    = 1'b0;
		waddr = p_q[AW-1:0];
		wdata = '0;
		unique case (ctl.op)
			btffa_pkg::OP_F_RDS: raddr = pend[AW-1:0];
			btffa_pkg::OP_F_RDN: raddr = AW'(s_q - 1'b1);
			btffa_pkg::OP_WR_A: begin
				we = 1'b1; waddr = p_q[AW-1:0];
				wdata = {(sts.split ? need_q : rsz), 1'b1};
			end
			btffa_pkg::OP_WR_B: begin
				we = 1'b1;
				waddr = AW'(p_q + (sts.split ? need_q : sz_q) - 1'b1);
				wdata = {(sts.split ? need_q : sz_q), 1'b1};
			end
			btffa_pkg::OP_WR_C: begin
				we = 1'b1; waddr = AW'(p_q + need_q);
				wdata = {SW'(sz_q - need_q), 1'b0};
			end
			btffa_pkg::OP_WR_D: begin
				we = 1'b1; waddr = AW'(p_q + sz_q - 1'b1);
				wdata = {SW'(sz_q - need_q), 1'b0};
			end
			btffa_pkg::OP_F_WRH: begin
				we = 1'b1; waddr = s_q[AW-1:0]; wdata = {sz_q, 1'b0};
			end
			btffa_pkg::OP_F_WRF: begin
				we = 1'b1; waddr = AW'(s_q + sz_q - 1'b1); wdata = {sz_q, 1'b0};
			end
			btffa_pkg::OP_CLR: begin
				we = 1'b1; waddr = clr_q[AW-1:0];
				wdata = (clr_q[AW-1:0] == '0 || clr_q[AW-1:0] == AW'(btffa_pkg::ARENA_WORDS - 1))
					? {SW'(btffa_pkg::ARENA_WORDS), 1'b0} : '0;
			end
			default: ;
		endcase
	end

	// tag memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// status towards the controller
	always_comb begin
		sts.clr_done  = clr_q[AW];
		sts.size_zero = need_q == SW'(2);
		sts.scan_end  = p_q[SW-1] || rsz == '0;
		sts.fit       = !ralloc && rsz >= need_q && pend <= (SW+1)'(btffa_pkg::ARENA_WORDS);
		sts.h_found   = !hvalid_q[h_q];
		sts.h_end     = h_q == HW'(MAX_H - 1);
		sts.hok       = hok_q;
		sts.split     = sz_q > need_q;
		sts.nx_merge  = !ralloc && rsz != '0 && pend <= (SW+1)'(btffa_pkg::ARENA_WORDS);
		sts.pv_merge  = s_q != '0 && !ralloc && rsz != '0 && rsz <= s_q;
	end

	assign hsel = h_q;
	assign base = p_q[AW-1:0];

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			clr_q    <= '0;
		end else begin
			unique case (ctl.op)
				btffa_pkg::OP_CLR: clr_q <= clr_q + 1'b1;
				btffa_pkg::OP_BIND: hvalid_q[h_q] <= 1'b1;
				btffa_pkg::OP_F_WRF: hvalid_q[hin_q[HW-1:0]] <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			btffa_pkg::OP_LOAD: begin
				// oversized requests saturate so that no block fits
				need_q <= nwords > 12'(btffa_pkg::ARENA_WORDS - 2) ? '1
					: SW'(nwords + 12'd2);
				hin_q  <= handle_in;
				hok_q  <= handle_in != '0 && hvalid_q[handle_in[HW-1:0]];
				p_q    <= cmd == btffa_pkg::CMD_ALLOC ? '0
					: SW'(hstart_q[handle_in[HW-1:0]]);
				h_q    <= HW'(1);
			end
			btffa_pkg::OP_STEP: p_q <= pend[SW-1:0];
			btffa_pkg::OP_RD_PTR: sz_q <= rsz;
			btffa_pkg::OP_HSCAN: h_q <= h_q + 1'b1;
			btffa_pkg::OP_BIND: hstart_q[h_q] <= p_q[AW-1:0];
			btffa_pkg::OP_F_RDS: begin
				s_q  <= p_q;
				sz_q <= rsz;
				p_q  <= pend[SW-1:0];
			end
			btffa_pkg::OP_F_RDN: begin
				if (!p_q[SW-1] && sts.nx_merge) sz_q <= sz_q + rsz;
			end
			btffa_pkg::OP_F_RDP: begin
				if (sts.pv_merge) begin
					s_q  <= s_q - rsz;
					sz_q <= sz_q + rsz;
				end
			end
			default: ;
		endcase
	end

	// a bind always sets the valid bit of the bound handle
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == btffa_pkg::OP_BIND |=> hvalid_q[$past(h_q)])
		else $error("bind lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == btffa_pkg::OP_CLR |-> !clr_q[AW])
		else $error("clear pass overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == btffa_pkg::OP_BIND |-> h_q != '0)
		else $error("null handle bound");

endmodule

// ===== design/btffa_ctrl.sv =====
module btffa_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_fire,
	input  logic [1:0]               cmd,
	input  btffa_pkg::sts_t          sts,
	output btffa_pkg::ctl_t          ctl,
	output logic                     busy,
	output logic                     done,
	output btffa_pkg::status_t       st,
	output logic                     give_h,
	output logic                     give_off
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_CHK, S_HS, S_WA, S_WB, S_WC, S_WD, S_BIND,
		S_FRS, S_FRN, S_FRP, S_FWH, S_FWF
	} state_t;

	state_t state_q;
	logic [1:0] cmd_q;

	always_comb begin
		ctl.op = btffa_pkg::OP_NONE;
		unique case (state_q)
			S_CLR:  ctl.op = sts.clr_done ? btffa_pkg::OP_NONE : btffa_pkg::OP_CLR;
			S_IDLE: ctl.op = in_fire ? btffa_pkg::OP_LOAD : btffa_pkg::OP_NONE;
			S_RD:   ctl.op = btffa_pkg::OP_NONE;
			S_CHK:  ctl.op = sts.fit ? btffa_pkg::OP_RD_PTR : btffa_pkg::OP_STEP;
			S_HS:   ctl.op = sts.h_found ? btffa_pkg::OP_NONE : btffa_pkg::OP_HSCAN;
			S_WA:   ctl.op = btffa_pkg::OP_WR_A;
			S_WB:   ctl.op = btffa_pkg::OP_WR_B;
			S_WC:   ctl.op = btffa_pkg::OP_WR_C;
			S_WD:   ctl.op = btffa_pkg::OP_WR_D;
			S_BIND: ctl.op = btffa_pkg::OP_BIND;
			S_FRS:  ctl.op = btffa_pkg::OP_F_RDS;
			S_FRN:  ctl.op = btffa_pkg::OP_F_RDN;
			S_FRP:  ctl.op = btffa_pkg::OP_F_RDP;
			S_FWH:  ctl.op = btffa_pkg::OP_F_WRH;
			S_FWF:  ctl.op = btffa_pkg::OP_F_WRF;
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;

	// sequencer with registered result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			cmd_q    <= '0;
			done     <= 1'b0;
			st       <= btffa_pkg::ST_OK;
			give_h   <= 1'b0;
			give_off <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (in_fire) begin
					cmd_q <= cmd;
					state_q <= S_RD;
				end
				S_RD: begin
					if (cmd_q == btffa_pkg::CMD_ALLOC) begin
						if (sts.size_zero) begin
							st <= btffa_pkg::ST_ZERO; give_h <= 1'b0; give_off <= 1'b0;
							done <= 1'b1; state_q <= S_IDLE;
						end else state_q <= S_CHK;
					end else if (sts.hok && cmd_q == btffa_pkg::CMD_RESOLVE) begin
						st <= btffa_pkg::ST_OK; give_h <= 1'b0; give_off <= 1'b1;
						done <= 1'b1; state_q <= S_IDLE;
					end else if (sts.hok && cmd_q == btffa_pkg::CMD_FREE) begin
						state_q <= S_FRS;
					end else begin
						st <= btffa_pkg::ST_BADH; give_h <= 1'b0; give_off <= 1'b0;
						done <= 1'b1; state_q <= S_IDLE;
					end
				end
				S_CHK: begin
					if (sts.scan_end) begin
						st <= btffa_pkg::ST_NOMEM; give_h <= 1'b0; give_off <= 1'b0;
						done <= 1'b1; state_q <= S_IDLE;
					end else if (sts.fit) state_q <= S_HS;
					else state_q <= S_RD;
				end
				S_HS: begin
					if (sts.h_found) state_q <= S_WA;
					else if (sts.h_end) begin
						st <= btffa_pkg::ST_HFULL; give_h <= 1'b0; give_off <= 1'b0;
						done <= 1'b1; state_q <= S_IDLE;
					end
				end
				S_WA: state_q <= S_WB;
				S_WB: state_q <= sts.split ? S_WC : S_BIND;
				S_WC: state_q <= S_WD;
				S_WD: state_q <= S_BIND;
				S_BIND: begin
					st <= btffa_pkg::ST_OK; give_h <= 1'b1; give_off <= 1'b1;
					done <= 1'b1; state_q <= S_IDLE;
				end
				S_FRS: state_q <= S_FRN;
				S_FRN: state_q <= S_FRP;
				S_FRP: state_q <= S_FWH;
				S_FWH: state_q <= S_FWF;
				S_FWF: begin
					st <= btffa_pkg::ST_OK; give_h <= 1'b0; give_off <= 1'b0;
					done <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE)
		else $error("result while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE)
		else $error("item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		done && give_h |-> st == btffa_pkg::ST_OK)
		else $error("handle given on failure");

endmodule

// ===== design/boundary_tag_first_fit_allocator.sv =====
// channel   dir  tdata fields (low bit up)                      tuser
// s_axis    in   cmd[1:0] size_bytes[15:2] handle_in[21:16]      -
// m_axis    out  status[2:0] handle_out[8:3] payload_offset[18:9] -
// an allocate checks each block header in turn, finds an unbound handle, writes
// header and footer of the block (and of the remainder on a split) and binds;
// a free reads the block and both neighbour tags and writes the merged ones;
// resolve, a zero request and a bad handle end at the header read; the result
// strobe and output are registered; after reset a clearing pass writes the arena
// before any item; a new item waits until the previous result has been taken
module boundary_tag_first_fit_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // cmd, size_bytes, handle_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status, handle_out, payload_offset
);

	btffa_pkg::ctl_t    ctl;
	btffa_pkg::sts_t    sts;
	btffa_pkg::status_t st;
	logic busy, done, give_h, give_off, in_fire;
	logic [btffa_pkg::HW-1:0] hsel;
	logic [btffa_pkg::AW-1:0] base;
	logic pend_q;
	logic [23:0] res_q;

	// a new item waits while a result is still held or being registered
	assign s_axis_tready = !busy && !pend_q && !done;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	btffa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .cmd(s_axis_tdata[1:0]),
		.sts(sts), .ctl(ctl), .busy(busy), .done(done), .st(st),
		.give_h(give_h), .give_off(give_off)
	);

	btffa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cmd(s_axis_tdata[1:0]), .size_bytes(s_axis_tdata[15:2]),
		.handle_in(s_axis_tdata[21:16]), .hsel(hsel), .base(base)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			res_q  <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) pend_q <= 1'b0;
			if (done) begin
				pend_q <= 1'b1;
				res_q  <= {5'd0,
					give_off ? 10'(base + 1'b1) : 10'd0,
					give_h ? 6'(hsel) : 6'd0, st};
			end
		end
	end

	assign m_axis_tvalid = pend_q;
	assign m_axis_tdata  = res_q;

endmodule
